// ----- hdl/rpyq_pkg.sv -----
// Shared constants, widths and arithmetic helpers for the angle-to-quaternion pipeline.
`timescale 1ns / 1ps
package rpyq_pkg;

   localparam int ANGLE_BITS_DEFAULT    = 16;
   localparam int OUT_FRAC_BITS_DEFAULT = 14;

   localparam int AXES         = 3;
   localparam int COMPS        = 4;
   localparam int CORDIC_STEPS = 30;
   localparam int TURN_W       = 32;
   localparam int RED_W        = 30;
   localparam int CS_W         = 32;
   localparam int Z_W          = 33;
   localparam int Q_W          = 33;
   localparam int SQ_W         = 64;
   localparam int SQRT_STEPS   = 32;
   localparam int NORM_W       = 32;

   localparam logic signed [CS_W-1:0] CORDIC_GAIN = 32'sd652032874;

   function automatic logic signed [Z_W-1:0] atan_turns(input int step);
      logic [31:0] v;
      case (step)
         0:  v = 32'h20000000;
         1:  v = 32'h12E4051D;
         2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;
         4:  v = 32'h028B0D43;
         5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;
         7:  v = 32'h00517C55;
         8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2E;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2F9;
         15: v = 32'h0000517C;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A2F;
         19: v = 32'h00000517;
         20: v = 32'h0000028B;
         21: v = 32'h00000145;
         22: v = 32'h000000A2;
         23: v = 32'h00000051;
         24: v = 32'h00000028;
         25: v = 32'h00000014;
         26: v = 32'h0000000A;
         27: v = 32'h00000005;
         28: v = 32'h00000002;
         29: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return signed'({1'b0, v});
   endfunction

   function automatic logic signed [CS_W-1:0] mul_q30(input logic signed [CS_W-1:0] a,
                                                      input logic signed [CS_W-1:0] b);
      logic signed [2*CS_W-1:0] p;
      p = a * b;
      return p[CS_W+29:30];
   endfunction

endpackage

// ----- hdl/rpyq_if.sv -----
// Valid/ready channel interfaces for angle items and quaternion items.
`timescale 1ns / 1ps
interface rpyq_req_if #(parameter int ANGLE_BITS = rpyq_pkg::ANGLE_BITS_DEFAULT);
   logic                  valid;
   logic                  ready;
   logic [ANGLE_BITS-1:0] roll_turns;
   logic [ANGLE_BITS-1:0] pitch_turns;
   logic [ANGLE_BITS-1:0] yaw_turns;
   modport source (output valid, output roll_turns, output pitch_turns, output yaw_turns,
                   input ready);
   modport sink (input valid, input roll_turns, input pitch_turns, input yaw_turns,
                 output ready);
endinterface

interface rpyq_rsp_if #(parameter int OUT_W = rpyq_pkg::OUT_FRAC_BITS_DEFAULT + 2);
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] quat_x;
   logic signed [OUT_W-1:0] quat_y;
   logic signed [OUT_W-1:0] quat_z;
   logic signed [OUT_W-1:0] quat_w;
   modport source (output valid, output quat_x, output quat_y, output quat_z, output quat_w,
                   input ready);
   modport sink (input valid, input quat_x, input quat_y, input quat_z, input quat_w,
                 output ready);
endinterface

// ----- hdl/rpyq_cordic.sv -----
// Pipelined rotation CORDIC giving cosine and sine of three half angles in parallel.
`timescale 1ns / 1ps
module rpyq_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic                                in_valid,
   input  logic [rpyq_pkg::RED_W-1:0]          angle [rpyq_pkg::AXES],
   input  logic                                upper [rpyq_pkg::AXES],
   output logic                                out_valid,
   output logic signed [rpyq_pkg::CS_W-1:0]    cos_out [rpyq_pkg::AXES],
   output logic signed [rpyq_pkg::CS_W-1:0]    sin_out [rpyq_pkg::AXES]
);
   localparam int STEPS = rpyq_pkg::CORDIC_STEPS;
   localparam int AXES  = rpyq_pkg::AXES;
   localparam int CS_W  = rpyq_pkg::CS_W;
   localparam int Z_W   = rpyq_pkg::Z_W;

   logic                   valid_ff [0:STEPS+1];
   logic signed [CS_W-1:0] x_ff     [0:STEPS][AXES];
   logic signed [CS_W-1:0] y_ff     [0:STEPS][AXES];
   logic signed [Z_W-1:0]  z_ff     [0:STEPS][AXES];
   logic                   up_ff    [0:STEPS][AXES];
   logic signed [CS_W-1:0] cos_ff   [AXES];
   logic signed [CS_W-1:0] sin_ff   [AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STEPS + 1; s++) valid_ff[s] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= STEPS + 1; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   for (genvar l = 0; l < AXES; l++) begin : g_lane
      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[0][l]  <= rpyq_pkg::CORDIC_GAIN;
            y_ff[0][l]  <= '0;
            z_ff[0][l]  <= signed'(Z_W'(angle[l]));
            up_ff[0][l] <= upper[l];
         end
      end

      for (genvar i = 0; i < STEPS; i++) begin : g_step
         logic signed [CS_W-1:0] dx, dy;
         assign dx = y_ff[i][l] >>> i;
         assign dy = x_ff[i][l] >>> i;
         always_ff @(posedge clock) begin
            if (enable) begin
               if (!z_ff[i][l][Z_W-1]) begin
                  x_ff[i+1][l] <= x_ff[i][l] - dx;
                  y_ff[i+1][l] <= y_ff[i][l] + dy;
                  z_ff[i+1][l] <= z_ff[i][l] - rpyq_pkg::atan_turns(i);
               end else begin
                  x_ff[i+1][l] <= x_ff[i][l] + dx;
                  y_ff[i+1][l] <= y_ff[i][l] - dy;
                  z_ff[i+1][l] <= z_ff[i][l] + rpyq_pkg::atan_turns(i);
               end
               up_ff[i+1][l] <= up_ff[i][l];
            end
         end
      end

      // swap back the quarter turn taken off before the rotations
      always_ff @(posedge clock) begin
         if (enable) begin
            if (up_ff[STEPS][l]) begin
               cos_ff[l] <= -y_ff[STEPS][l];
               sin_ff[l] <= x_ff[STEPS][l];
            end else begin
               cos_ff[l] <= x_ff[STEPS][l];
               sin_ff[l] <= y_ff[STEPS][l];
            end
         end
      end

      assign cos_out[l] = cos_ff[l];
      assign sin_out[l] = sin_ff[l];
   end

   assign out_valid = valid_ff[STEPS+1];

endmodule

// ----- hdl/rpyq_isqrt.sv -----
// Pipelined floor integer square root, one result bit a stage, with a carried tag.
`timescale 1ns / 1ps
module rpyq_isqrt #(
   parameter int TAG_W = 4 * rpyq_pkg::Q_W
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  logic                               in_valid,
   input  logic [rpyq_pkg::SQ_W-1:0]          radicand,
   input  logic [TAG_W-1:0]                   in_tag,
   output logic                               out_valid,
   output logic [rpyq_pkg::NORM_W-1:0]        root,
   output logic [TAG_W-1:0]                   out_tag
);
   localparam int STEPS = rpyq_pkg::SQRT_STEPS;
   localparam int SQ_W  = rpyq_pkg::SQ_W;

   logic             valid_ff [0:STEPS];
   logic [SQ_W-1:0]  v_ff     [0:STEPS];
   logic [SQ_W-1:0]  r_ff     [0:STEPS];
   logic [TAG_W-1:0] tag_ff   [0:STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STEPS; s++) valid_ff[s] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= STEPS; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         v_ff[0]   <= radicand;
         r_ff[0]   <= '0;
         tag_ff[0] <= in_tag;
      end
   end

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * s);
      logic [SQ_W-1:0] trial_in;
      assign trial_in = r_ff[s] + BIT;
      always_ff @(posedge clock) begin
         if (enable) begin
            if (v_ff[s] >= trial_in) begin
               v_ff[s+1] <= v_ff[s] - trial_in;
               r_ff[s+1] <= (r_ff[s] >> 1) + BIT;
            end else begin
               v_ff[s+1] <= v_ff[s];
               r_ff[s+1] <= r_ff[s] >> 1;
            end
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign root      = r_ff[STEPS][rpyq_pkg::NORM_W-1:0];
   assign out_tag   = tag_ff[STEPS];

endmodule

// ----- hdl/rpyq_to_quaternion_core.sv -----
// Top level: roll, pitch and yaw angles in, normalised Q1.F quaternion out.
// Pipeline stages: 32 CORDIC, 5 product and norm-sum, 33 square root,
// OUT_FRAC_BITS + 2 division and 1 output stage.
// Throughput: one item per cycle; the whole pipeline holds while the result is not taken.
// Reset clears the valid bits only; the data registers are not reset.
`timescale 1ns / 1ps
module rpy_to_quaternion_core #(
   parameter int ANGLE_BITS    = rpyq_pkg::ANGLE_BITS_DEFAULT,
   parameter int OUT_FRAC_BITS = rpyq_pkg::OUT_FRAC_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   rpyq_req_if.sink   req_ch,
   rpyq_rsp_if.source rsp_ch
);
   localparam int AXES   = rpyq_pkg::AXES;
   localparam int COMPS  = rpyq_pkg::COMPS;
   localparam int CS_W   = rpyq_pkg::CS_W;
   localparam int Q_W    = rpyq_pkg::Q_W;
   localparam int SQ_W   = rpyq_pkg::SQ_W;
   localparam int NORM_W = rpyq_pkg::NORM_W;
   localparam int RED_W  = rpyq_pkg::RED_W;
   localparam int TURN_W = rpyq_pkg::TURN_W;
   localparam int F      = OUT_FRAC_BITS;
   localparam int OUT_W  = F + 2;
   localparam int QUO_W  = F + 1;
   localparam int NUM_W  = NORM_W + F + 1;
   localparam int TAG_W  = COMPS * Q_W;

   logic advance;
   assign advance      = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = advance;

   // angle prep: scale to a 32-bit turn, halve, take off a quarter turn
   logic [ANGLE_BITS-1:0] angle_raw [AXES];
   logic [RED_W-1:0]      red_angle [AXES];
   logic                  red_upper [AXES];
   assign angle_raw[0] = req_ch.roll_turns;
   assign angle_raw[1] = req_ch.pitch_turns;
   assign angle_raw[2] = req_ch.yaw_turns;

   for (genvar a = 0; a < AXES; a++) begin : g_prep
      logic [TURN_W-1:0] turn_in, half_in;
      assign turn_in      = TURN_W'(angle_raw[a]) << (TURN_W - ANGLE_BITS);
      assign half_in      = turn_in >> 1;
      assign red_upper[a] = half_in[RED_W];
      assign red_angle[a] = half_in[RED_W-1:0];
   end

   logic                   cs_valid;
   logic signed [CS_W-1:0] cs_cos [AXES];
   logic signed [CS_W-1:0] cs_sin [AXES];

   rpyq_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_ch.valid),
      .angle     (red_angle),
      .upper     (red_upper),
      .out_valid (cs_valid),
      .cos_out   (cs_cos),
      .sin_out   (cs_sin)
   );

   // products, quaternion, squares, squared norm
   logic                   p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff, p5_valid_ff;
   logic signed [CS_W-1:0] sc_ff, cs_ff, cc_ff, ss_ff, cy_ff, sy_ff;
   logic signed [CS_W-1:0] m_ff [8];
   logic signed [Q_W-1:0]  q3_ff [COMPS];
   logic signed [Q_W-1:0]  q4_ff [COMPS];
   logic signed [Q_W-1:0]  q5_ff [COMPS];
   logic [SQ_W-1:0]        sq_ff [COMPS];
   logic [SQ_W-1:0]        n2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= cs_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
         p5_valid_ff <= p4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sc_ff <= rpyq_pkg::mul_q30(cs_sin[0], cs_cos[1]);
         cs_ff <= rpyq_pkg::mul_q30(cs_cos[0], cs_sin[1]);
         cc_ff <= rpyq_pkg::mul_q30(cs_cos[0], cs_cos[1]);
         ss_ff <= rpyq_pkg::mul_q30(cs_sin[0], cs_sin[1]);
         cy_ff <= cs_cos[2];
         sy_ff <= cs_sin[2];

         m_ff[0] <= rpyq_pkg::mul_q30(sc_ff, cy_ff);
         m_ff[1] <= rpyq_pkg::mul_q30(cs_ff, sy_ff);
         m_ff[2] <= rpyq_pkg::mul_q30(cs_ff, cy_ff);
         m_ff[3] <= rpyq_pkg::mul_q30(sc_ff, sy_ff);
         m_ff[4] <= rpyq_pkg::mul_q30(cc_ff, sy_ff);
         m_ff[5] <= rpyq_pkg::mul_q30(ss_ff, cy_ff);
         m_ff[6] <= rpyq_pkg::mul_q30(cc_ff, cy_ff);
         m_ff[7] <= rpyq_pkg::mul_q30(ss_ff, sy_ff);

         q3_ff[0] <= Q_W'(m_ff[0]) - Q_W'(m_ff[1]);
         q3_ff[1] <= Q_W'(m_ff[2]) + Q_W'(m_ff[3]);
         q3_ff[2] <= Q_W'(m_ff[4]) - Q_W'(m_ff[5]);
         q3_ff[3] <= Q_W'(m_ff[6]) + Q_W'(m_ff[7]);

         for (int c = 0; c < COMPS; c++) begin
            q4_ff[c] <= q3_ff[c];
            q5_ff[c] <= q4_ff[c];
         end
         n2_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2] + sq_ff[3];
      end
   end

   for (genvar c = 0; c < COMPS; c++) begin : g_square
      logic signed [Q_W-1:0] abs_in;
      logic [CS_W-1:0]       mag_in;
      assign abs_in = q3_ff[c][Q_W-1] ? -q3_ff[c] : q3_ff[c];
      assign mag_in = abs_in[CS_W-1:0];
      always_ff @(posedge clock) begin
         if (advance) sq_ff[c] <= SQ_W'(mag_in) * SQ_W'(mag_in);
      end
   end

   // norm
   logic [TAG_W-1:0]  tag_in, tag_out;
   logic              rt_valid;
   logic [NORM_W-1:0] rt_norm;
   assign tag_in = {q5_ff[3], q5_ff[2], q5_ff[1], q5_ff[0]};

   rpyq_isqrt #(.TAG_W(TAG_W)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (p5_valid_ff),
      .radicand  (n2_ff),
      .in_tag    (tag_in),
      .out_valid (rt_valid),
      .root      (rt_norm),
      .out_tag   (tag_out)
   );

   // division by the norm, one quotient bit a stage
   logic              dv_valid_ff [0:QUO_W];
   logic [NORM_W-1:0] dv_norm_ff  [0:QUO_W];
   logic              dv_zero_ff  [0:QUO_W];
   logic [NUM_W-1:0]  rem_ff      [0:QUO_W][COMPS];
   logic [QUO_W-1:0]  quo_ff      [0:QUO_W][COMPS];
   logic              neg_ff      [0:QUO_W][COMPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QUO_W; s++) dv_valid_ff[s] <= 1'b0;
      end else if (advance) begin
         dv_valid_ff[0] <= rt_valid;
         for (int s = 1; s <= QUO_W; s++) dv_valid_ff[s] <= dv_valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_norm_ff[0] <= rt_norm;
         dv_zero_ff[0] <= (rt_norm == '0);
         for (int s = 1; s <= QUO_W; s++) begin
            dv_norm_ff[s] <= dv_norm_ff[s-1];
            dv_zero_ff[s] <= dv_zero_ff[s-1];
         end
      end
   end

   for (genvar c = 0; c < COMPS; c++) begin : g_div
      logic signed [Q_W-1:0] qv_in, abs_in;
      logic [NORM_W-1:0]     mag_in;
      assign qv_in  = signed'(tag_out[c*Q_W +: Q_W]);
      assign abs_in = qv_in[Q_W-1] ? -qv_in : qv_in;
      assign mag_in = abs_in[NORM_W-1:0];

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[0][c] <= (NUM_W'(mag_in) << F) + NUM_W'(rt_norm >> 1);
            quo_ff[0][c] <= '0;
            neg_ff[0][c] <= qv_in[Q_W-1];
         end
      end

      for (genvar s = 0; s < QUO_W; s++) begin : g_bit
         logic [NUM_W-1:0] dvs_in;
         logic             take_in;
         assign dvs_in  = NUM_W'(dv_norm_ff[s]) << (F - s);
         assign take_in = rem_ff[s][c] >= dvs_in;
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[s+1][c] <= take_in ? rem_ff[s][c] - dvs_in : rem_ff[s][c];
               quo_ff[s+1][c] <= {quo_ff[s][c][QUO_W-2:0], take_in};
               neg_ff[s+1][c] <= neg_ff[s][c];
            end
         end
      end
   end

   // saturate, apply sign, output register
   localparam logic [QUO_W-1:0] ONE = QUO_W'(1) << F;
   logic                    out_valid_ff;
   logic signed [OUT_W-1:0] out_ff [COMPS];
   logic signed [OUT_W-1:0] res_in [COMPS];

   always_comb begin
      logic [QUO_W-1:0] sat;
      for (int c = 0; c < COMPS; c++) begin
         sat = (quo_ff[QUO_W][c] > ONE) ? ONE : quo_ff[QUO_W][c];
         if (dv_zero_ff[QUO_W]) begin
            res_in[c] = (c == COMPS - 1) ? signed'(OUT_W'(ONE)) : '0;
         end else if (neg_ff[QUO_W][c]) begin
            res_in[c] = signed'(OUT_W'(0) - OUT_W'(sat));
         end else begin
            res_in[c] = signed'(OUT_W'(sat));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_valid_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < COMPS; c++) out_ff[c] <= res_in[c];
      end
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.quat_x = out_ff[0];
   assign rsp_ch.quat_y = out_ff[1];
   assign rsp_ch.quat_z = out_ff[2];
   assign rsp_ch.quat_w = out_ff[3];

endmodule

// ----- sim/tb_rpy_to_quaternion_core.sv -----
// Testbench for rpy_to_quaternion_core: directed and random angle triples against a predictor.
`timescale 1ns / 1ps
module tb_rpy_to_quaternion_core;

   localparam int AB       = rpyq_pkg::ANGLE_BITS_DEFAULT;
   localparam int OF       = rpyq_pkg::OUT_FRAC_BITS_DEFAULT;
   localparam int OW       = OF + 2;
   localparam int LATENCY  = OF + 73;
   localparam int WD_LIMIT = 20000;
   localparam int N_RANDOM = 1130;
   localparam int N_DIR    = 16;

   typedef struct packed {
      logic signed [OW-1:0] x;
      logic signed [OW-1:0] y;
      logic signed [OW-1:0] z;
      logic signed [OW-1:0] w;
   } quat_type;

   typedef struct {
      logic [AB-1:0] r;
      logic [AB-1:0] p;
      logic [AB-1:0] yw;
      bit            known;
      quat_type      q;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rpyq_req_if #(.ANGLE_BITS(AB)) req_ch ();
   rpyq_rsp_if #(.OUT_W(OW))      rsp_ch ();

   rpy_to_quaternion_core #(.ANGLE_BITS(AB), .OUT_FRAC_BITS(OF)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #10 clock = ~clock;

   quat_type    quat_pending[$];
   dir_row_type dir_rows[N_DIR];
   int          errors    = 0;
   int          n_sent    = 0;
   int          n_checked = 0;
   int          idle_cycles = 0;
   int          send_gap_pct = 0;
   int          take_gap_pct = 0;
   bit          stim_done = 1'b0;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void half_trig(logic [31:0] h, output longint c, output longint s);
      longint z, xv, yv, dx, dy, a;
      bit     upper;
      upper = h >= 32'h40000000;
      z  = upper ? longint'(h - 32'h40000000) : longint'(h);
      xv = 652032874;
      yv = 0;
      for (int i = 0; i < rpyq_pkg::CORDIC_STEPS; i++) begin
         a  = longint'(rpyq_pkg::atan_turns(i));
         dx = floor_shift(yv, i);
         dy = floor_shift(xv, i);
         if (z >= 0) begin
            xv -= dx; yv += dy; z -= a;
         end else begin
            xv += dx; yv -= dy; z += a;
         end
      end
      if (upper) begin
         c = -yv; s = xv;
      end else begin
         c = xv; s = yv;
      end
   endfunction

   function automatic void angle_trig(logic [AB-1:0] ang, output longint c, output longint s);
      logic [31:0] t;
      t = {ang, {(32-AB){1'b0}}};
      half_trig(t >> 1, c, s);
   endfunction

   function automatic longint prod30(longint a, longint b);
      return (a * b) >>> 30;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [OW-1:0] to_q1(longint c, longint unsigned nrm);
      longint unsigned mag, q, one;
      mag = c < 0 ? longint'(-c) : c;
      one = 64'd1 << OF;
      q = ((mag << OF) + nrm / 2) / nrm;
      if (q > one) q = one;
      if (c < 0) q = -q;
      return q[OW-1:0];
   endfunction

   function automatic quat_type euler_to_quat(logic [AB-1:0] r, logic [AB-1:0] p,
                                              logic [AB-1:0] yw);
      longint          cr, sr, cp, sp, cy, sy;
      longint          c[4];
      longint unsigned n2, m, nrm;
      quat_type        res;
      angle_trig(r, cr, sr);
      angle_trig(p, cp, sp);
      angle_trig(yw, cy, sy);
      c[0] = prod30(prod30(sr, cp), cy) - prod30(prod30(cr, sp), sy);
      c[1] = prod30(prod30(cr, sp), cy) + prod30(prod30(sr, cp), sy);
      c[2] = prod30(prod30(cr, cp), sy) - prod30(prod30(sr, sp), cy);
      c[3] = prod30(prod30(cr, cp), cy) + prod30(prod30(sr, sp), sy);
      n2 = 0;
      for (int k = 0; k < 4; k++) begin
         m = c[k] < 0 ? longint'(-c[k]) : c[k];
         n2 += m * m;
      end
      nrm = root_floor(n2);
      if (nrm == 0) begin
         res.x = '0; res.y = '0; res.z = '0; res.w = OW'(1 << OF);
         return res;
      end
      res.x = to_q1(c[0], nrm);
      res.y = to_q1(c[1], nrm);
      res.z = to_q1(c[2], nrm);
      res.w = to_q1(c[3], nrm);
      return res;
   endfunction

   task automatic send_item(logic [AB-1:0] r, logic [AB-1:0] p, logic [AB-1:0] yw,
                            bit known, quat_type q);
      quat_type want_q;
      want_q = known ? q : euler_to_quat(r, p, yw);
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.roll_turns  <= r;
      req_ch.pitch_turns <= p;
      req_ch.yaw_turns   <= yw;
      quat_pending = {quat_pending, want_q};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      n_sent++;
   endtask

   function automatic logic [AB-1:0] rand_angle();
      case ($urandom_range(3))
         0:       return AB'($urandom_range(3)) << (AB - 2);
         1:       return AB'((AB'($urandom_range(3)) << (AB - 2)) + AB'($urandom_range(4)) - 2);
         default: return AB'($urandom);
      endcase
   endfunction

   initial begin
      quat_type ident, roll_half;
      ident = '{x: 0, y: 0, z: 0, w: 16384};
      roll_half = '{x: 16384, y: 0, z: 0, w: 0};
      dir_rows[0]  = '{16'h0000, 16'h0000, 16'h0000, 1'b1, ident};
      dir_rows[1]  = '{16'h8000, 16'h0000, 16'h0000, 1'b1, roll_half};
      dir_rows[2]  = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, ident};
      dir_rows[3]  = '{16'h4000, 16'h0000, 16'h0000, 1'b0, ident};
      dir_rows[4]  = '{16'hC000, 16'h0000, 16'h0000, 1'b0, ident};
      dir_rows[5]  = '{16'h0000, 16'h4000, 16'h0000, 1'b0, ident};
      dir_rows[6]  = '{16'h0000, 16'h8000, 16'h0000, 1'b0, ident};
      dir_rows[7]  = '{16'h0000, 16'h0000, 16'h4000, 1'b0, ident};
      dir_rows[8]  = '{16'h0000, 16'h0000, 16'h8000, 1'b0, ident};
      dir_rows[9]  = '{16'h0001, 16'h0001, 16'h0001, 1'b0, ident};
      dir_rows[10] = '{16'h7FFF, 16'h8001, 16'h3FFF, 1'b0, ident};
      dir_rows[11] = '{16'h8000, 16'h8000, 16'h8000, 1'b0, ident};
      dir_rows[12] = '{16'h5555, 16'hAAAA, 16'h5555, 1'b0, ident};
      dir_rows[13] = '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, ident};
      dir_rows[14] = '{16'hFFFF, 16'h0000, 16'h8000, 1'b0, ident};
      dir_rows[15] = '{16'h2000, 16'h4000, 16'hE000, 1'b0, ident};

      req_ch.valid       = 1'b0;
      req_ch.roll_turns  = '0;
      req_ch.pitch_turns = '0;
      req_ch.yaw_turns   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < 3; ph++) begin
         send_gap_pct = ph == 0 ? 7 : ph == 1 ? 57 : 0;
         take_gap_pct = ph == 0 ? 57 : ph == 1 ? 7 : 0;
         if (ph == 0)
            foreach (dir_rows[i])
               send_item(dir_rows[i].r, dir_rows[i].p, dir_rows[i].yw,
                         dir_rows[i].known, dir_rows[i].q);
         for (int n = 0; n < N_RANDOM / 3; n++)
            send_item(rand_angle(), rand_angle(), rand_angle(), 1'b0, ident);
      end
      req_ch.valid <= 1'b0;
      while (quat_pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      stim_done = 1'b1;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= $urandom_range(99) >= take_gap_pct;
      end
   end

   always @(posedge clock) begin
      quat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_checked++;
         if (quat_pending.size() == 0) begin
            $error("unexpected result x=%0d y=%0d z=%0d w=%0d",
                   rsp_ch.quat_x, rsp_ch.quat_y, rsp_ch.quat_z, rsp_ch.quat_w);
            errors++;
         end else begin
            want = quat_pending.pop_front();
            if (rsp_ch.quat_x !== want.x) begin
               $error("quat_x expected %0d got %0d", want.x, rsp_ch.quat_x); errors++;
            end
            if (rsp_ch.quat_y !== want.y) begin
               $error("quat_y expected %0d got %0d", want.y, rsp_ch.quat_y); errors++;
            end
            if (rsp_ch.quat_z !== want.z) begin
               $error("quat_z expected %0d got %0d", want.z, rsp_ch.quat_z); errors++;
            end
            if (rsp_ch.quat_w !== want.w) begin
               $error("quat_w expected %0d got %0d", want.w, rsp_ch.quat_w); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      @(negedge clock);
      while (!stim_done && idle_cycles < WD_LIMIT) @(negedge clock);
      if (!stim_done) begin
         $display("watchdog expired with %0d results outstanding", quat_pending.size());
         $display("FAIL rpy_to_quaternion_core");
      end else begin
         $display("%0d angle triples sent, %0d quaternions checked, %0d mismatches",
                  n_sent, n_checked, errors);
         $display("covered quarter-turn extremes, wrap codes and three idle mixes");
         if (errors == 0 && quat_pending.size() == 0)
            $display("PASS rpy_to_quaternion_core");
         else
            $display("FAIL rpy_to_quaternion_core");
      end
      $finish;
   end

endmodule
